// File: rtl/pcu_pkg.sv
// ----------------------------------------------------------------------------
// pcu_pkg
// shared constants, mode codes and helpers for the pixel compositing unit
// ----------------------------------------------------------------------------
package pcu_pkg;

  localparam logic [15:0] ONE  = 16'h8000;
  localparam logic [15:0] HALF = 16'h4000;
  localparam int          FRAC = 15;

  localparam logic [2:0] MODE_OVER      = 3'd0;
  localparam logic [2:0] MODE_CMP_ALPHA = 3'd1;
  localparam logic [2:0] MODE_OVERWRITE = 3'd2;
  localparam logic [2:0] MODE_ERASE     = 3'd3;
  localparam logic [2:0] MODE_DODGE     = 3'd4;
  localparam logic [2:0] MODE_BURN      = 3'd5;
  localparam logic [2:0] MODE_ADD       = 3'd6;
  localparam logic [2:0] MODE_INV_ALPHA = 3'd7;

  // divider shape: 17 quotient bits, one per stage
  localparam int QBITS   = 17;
  localparam int XW      = 49;
  localparam int YW      = 32;
  localparam int LANE_ST = 3 + QBITS;
  localparam int NST     = LANE_ST + 1;

  typedef logic [15:0] chan_t;

  function automatic chan_t clamp_ch(input logic [15:0] v);
    clamp_ch = (v > ONE) ? ONE : v;
  endfunction

endpackage

// File: rtl/pcu_lane.sv
// ----------------------------------------------------------------------------
// pcu_lane
// one colour channel: products, ratio setup and a pipelined restoring divider
// ----------------------------------------------------------------------------
module pcu_lane import pcu_pkg::*; (
  input  logic               clk,
  input  logic [LANE_ST-1:0] en,
  input  chan_t              d_in,
  input  chan_t              s_in,
  input  chan_t              sa_in,
  input  chan_t              da_in,
  input  logic [2:0]         mode_in,
  output chan_t              col
);

  // stage 0: products
  chan_t       d0_r, s0_r, sa0_r, da0_r;
  logic [2:0]  mode0_r;
  logic [30:0] ps0_r, pd0_r, sada0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d0_r    <= d_in;
      s0_r    <= s_in;
      sa0_r   <= sa_in;
      da0_r   <= da_in;
      mode0_r <= mode_in;
      ps0_r   <= 31'(32'(s_in) * 32'(sa_in));
      pd0_r   <= 31'(32'(d_in) * 32'(da_in));
      sada0_r <= 31'(32'(sa_in) * 32'(da_in));
    end
  end

  // stage 1: second product and normaliser
  chan_t       d1_r, s1_r, sa1_r, da1_r;
  logic [2:0]  mode1_r;
  logic [30:0] ps1_r;
  logic [45:0] t1_r;
  logic [31:0] n1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_r    <= d0_r;
      s1_r    <= s0_r;
      sa1_r   <= sa0_r;
      da1_r   <= da0_r;
      mode1_r <= mode0_r;
      ps1_r   <= ps0_r;
      t1_r    <= 46'(46'(pd0_r) * 46'(ONE - sa0_r));
      n1_r    <= (32'(sa0_r) << FRAC) + (32'(da0_r) << FRAC) - 32'(sada0_r);
    end
  end

  // stage 2: dividend and divisor, or a direct colour
  logic [XW-1:0] x_nxt, x2_r;
  logic [YW-1:0] y_nxt, y2_r;
  logic          sel_nxt, sel2_r;
  chan_t         byp_nxt, byp2_r;
  chan_t         den;
  logic [16:0]   add_sum;

  always_comb begin
    den     = ONE - sa1_r;
    add_sum = 17'(d1_r) + 17'(ps1_r >> FRAC);
    x_nxt   = '0;
    y_nxt   = '0;
    sel_nxt = 1'b0;
    byp_nxt = d1_r;
    case (mode1_r)
      MODE_OVER: begin
        if (sa1_r == ONE) begin
          byp_nxt = s1_r;
        end else begin
          sel_nxt = 1'b1;
          x_nxt   = (XW'(ps1_r) << 16) + (XW'(t1_r) << 1) + XW'(n1_r);
          y_nxt   = YW'(n1_r) << 1;
        end
      end
      MODE_CMP_ALPHA: begin
        byp_nxt = (sa1_r <= da1_r && da1_r == 16'd0) ? d1_r : s1_r;
      end
      MODE_OVERWRITE: byp_nxt = s1_r;
      MODE_DODGE: begin
        if (sa1_r == ONE) begin
          byp_nxt = ONE;
        end else begin
          sel_nxt = 1'b1;
          x_nxt   = (XW'(d1_r) << 16) + XW'(den);
          y_nxt   = YW'(den) << 1;
        end
      end
      MODE_BURN: begin
        if (sa1_r == ONE || d1_r <= sa1_r) begin
          byp_nxt = '0;
        end else begin
          sel_nxt = 1'b1;
          x_nxt   = (XW'(d1_r - sa1_r) << 16) + XW'(den);
          y_nxt   = YW'(den) << 1;
        end
      end
      MODE_ADD: byp_nxt = (add_sum > 17'(ONE)) ? ONE : add_sum[15:0];
      default:  byp_nxt = d1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x2_r   <= x_nxt;
      y2_r   <= y_nxt;
      sel2_r <= sel_nxt;
      byp2_r <= byp_nxt;
    end
  end

  // divider stages, most significant quotient bit first
  logic [XW-1:0]    rem_r [QBITS];
  logic [QBITS-1:0] q_r   [QBITS];
  logic [YW-1:0]    y_r   [QBITS];
  logic             sel_r [QBITS];
  logic             ovf_r [QBITS];
  chan_t            byp_r [QBITS];

  genvar j;
  generate
    for (j = 0; j < QBITS; j++) begin : g_div
      localparam int B = QBITS - 1 - j;
      logic [XW-1:0]    rem_in, ysh, rem_nxt;
      logic [QBITS-1:0] q_in;
      logic [YW-1:0]    y_in;
      logic             sel_in, ovf_in, ge;
      chan_t            byp_in;

      if (j == 0) begin : g_first
        assign rem_in = x2_r;
        assign q_in   = '0;
        assign y_in   = y2_r;
        assign sel_in = sel2_r;
        assign byp_in = byp2_r;
        assign ovf_in = (XW'(y2_r) << QBITS) <= x2_r;
      end else begin : g_rest
        assign rem_in = rem_r[j-1];
        assign q_in   = q_r[j-1];
        assign y_in   = y_r[j-1];
        assign sel_in = sel_r[j-1];
        assign byp_in = byp_r[j-1];
        assign ovf_in = ovf_r[j-1];
      end

      assign ysh     = XW'(y_in) << B;
      assign ge      = rem_in >= ysh;
      assign rem_nxt = ge ? (rem_in - ysh) : rem_in;

      always_ff @(posedge clk) begin
        if (en[3+j]) begin
          rem_r[j] <= rem_nxt;
          q_r[j]   <= q_in | (QBITS'(ge) << B);
          y_r[j]   <= y_in;
          sel_r[j] <= sel_in;
          ovf_r[j] <= ovf_in;
          byp_r[j] <= byp_in;
        end
      end
    end
  endgenerate

  logic [QBITS-1:0] q_fin;
  assign q_fin = q_r[QBITS-1];
  assign col   = !sel_r[QBITS-1] ? byp_r[QBITS-1] :
                 (ovf_r[QBITS-1] || q_fin > QBITS'(ONE)) ? ONE : q_fin[15:0];

endmodule

// File: rtl/pixel_compositing_unit_top.sv
// ----------------------------------------------------------------------------
// pixel_compositing_unit_top
// rgba compositing with eight blend modes, three colour lanes and alpha path
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tdata  128 b, dst rgba then src rgba
// out_     out  out_tvalid/out_tready  out_tdata  64 b, result rgba
// cfg_     in   cfg_valid/cfg_ready    cfg_data    3 b, blend mode
//
// one pixel per cycle unless the output stalls; most of the depth is the 17-stage divider
// each stage holds its transaction when the next one is full and stalled
// synchronous active-low reset clears valids and the mode register
// cfg_ready is always high
// ----------------------------------------------------------------------------
module pixel_compositing_unit_top import pcu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // dst_red, dst_green, dst_blue, dst_alpha, src_red, src_green, src_blue, src_alpha
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [63:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_data
);

  logic [2:0]     mode_r;
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OVER;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  chan_t d_c [4];
  chan_t s_c [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_c[i] = clamp_ch(in_tdata[16*i +: 16]);
      s_c[i] = clamp_ch(in_tdata[64 + 16*i +: 16]);
    end
  end

  chan_t lane_col [3];

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      pcu_lane u_lane (
        .clk     (clk),
        .en      (en[LANE_ST-1:0]),
        .d_in    (d_c[g]),
        .s_in    (s_c[g]),
        .sa_in   (s_c[3]),
        .da_in   (d_c[3]),
        .mode_in (mode_r),
        .col     (lane_col[g])
      );
    end
  endgenerate

  // alpha path
  chan_t       sa0_r, da0_r, sa1_r, da1_r;
  logic [2:0]  mode0_r, mode1_r;
  logic [30:0] sada1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sa0_r   <= s_c[3];
      da0_r   <= d_c[3];
      mode0_r <= mode_r;
    end
    if (en[1]) begin
      sa1_r   <= sa0_r;
      da1_r   <= da0_r;
      mode1_r <= mode0_r;
      sada1_r <= 31'(32'(sa0_r) * 32'(da0_r));
    end
  end

  logic [31:0] n_a, n_rnd;
  chan_t       a_nxt;
  logic        clr_nxt;

  always_comb begin
    n_a     = (32'(sa1_r) << FRAC) + (32'(da1_r) << FRAC) - 32'(sada1_r);
    n_rnd   = (n_a + 32'(HALF)) >> FRAC;
    a_nxt   = da1_r;
    clr_nxt = 1'b0;
    case (mode1_r)
      MODE_OVER: begin
        if (sa1_r == ONE) begin
          a_nxt = ONE;
        end else begin
          a_nxt   = n_rnd[15:0];
          clr_nxt = (n_rnd == 32'd0);
        end
      end
      MODE_CMP_ALPHA: a_nxt = (sa1_r > da1_r) ? sa1_r : da1_r;
      MODE_OVERWRITE: a_nxt = sa1_r;
      MODE_ERASE: begin
        clr_nxt = (da1_r <= sa1_r);
        a_nxt   = da1_r - sa1_r;
      end
      MODE_INV_ALPHA: begin
        clr_nxt = (sa1_r == 16'd0);
        a_nxt   = ONE - da1_r;
      end
      default: a_nxt = da1_r;
    endcase
  end

  chan_t a_r   [2:LANE_ST-1];
  logic  clr_r [2:LANE_ST-1];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a_r[2]   <= a_nxt;
      clr_r[2] <= clr_nxt;
    end
    for (int k = 3; k < LANE_ST; k++) begin
      if (en[k]) begin
        a_r[k]   <= a_r[k-1];
        clr_r[k] <= clr_r[k-1];
      end
    end
  end

  // merge lanes and alpha into the output register
  chan_t out_r_r, out_g_r, out_b_r, out_a_r;
  logic  clr_fin;

  assign clr_fin = clr_r[LANE_ST-1];

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_r_r <= clr_fin ? '0 : lane_col[0];
      out_g_r <= clr_fin ? '0 : lane_col[1];
      out_b_r <= clr_fin ? '0 : lane_col[2];
      out_a_r <= clr_fin ? '0 : a_r[LANE_ST-1];
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = {out_a_r, out_b_r, out_g_r, out_r_r};

  a_alpha_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_a_r <= ONE)
    else $error("result alpha above one");

  a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_r_r <= ONE && out_g_r <= ONE && out_b_r <= ONE))
    else $error("result colour above one");

  a_accept_loads : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("accepted transaction not held in first stage");

  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v_r[0])
    else $error("input stalled with empty first stage");

endmodule
